### rtl/light_mode_controller_unit_macros.svh
// Assertion macros for the lamp mode controller.
`ifndef LIGHT_MODE_CONTROLLER_UNIT_MACROS_SVH
`define LIGHT_MODE_CONTROLLER_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define LMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define LMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lmc_pkg.sv
// Package with types, codes and helpers of the lamp mode controller.
`default_nettype none
package lmc_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int OUT_LVL_W  = 8;
  localparam int STORE_W    = (LEVEL_BITS < OUT_LVL_W) ? LEVEL_BITS : OUT_LVL_W;
  localparam int OP_W       = 4;
  localparam int LUX_W      = 16;
  localparam int MODE_W     = 3;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_RES_W  = MODE_W + 1 + 2 * OUT_LVL_W;
  localparam int OUT_TDATA_W = ((OUT_RES_W + 7) / 8) * 8;

  localparam logic [LUX_W-1:0] LUX_THRESH_RST = 16'd1000;

  localparam logic [MODE_W-1:0] MODE_CODE_AUTO_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_AUTO_DIM   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_MOTION     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_MANUAL_ON  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_MANUAL_OFF = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_TEMP_DIM   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_FAULT      = 3'd6;

  typedef enum logic [6:0] {
    MODE_AUTO_OFF   = 7'b0000001,
    MODE_AUTO_DIM   = 7'b0000010,
    MODE_MOTION     = 7'b0000100,
    MODE_MANUAL_ON  = 7'b0001000,
    MODE_MANUAL_OFF = 7'b0010000,
    MODE_TEMP_DIM   = 7'b0100000,
    MODE_FAULT      = 7'b1000000
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    EV_DARK       = 4'd0,
    EV_LIGHT      = 4'd1,
    EV_MOTION     = 4'd2,
    EV_MOTION_TO  = 4'd3,
    EV_OVR_ON     = 4'd4,
    EV_OVR_OFF    = 4'd5,
    EV_TEMP_DIM   = 4'd6,
    EV_RESUME     = 4'd7,
    EV_MAN_TO     = 4'd8,
    EV_DIM_EXP    = 4'd9,
    EV_FAULT      = 4'd10,
    EV_FAULT_CLR  = 4'd11
  } event_t;

  typedef struct packed {
    mode_t              mode;
    logic [STORE_W-1:0] man_lvl;
    logic [STORE_W-1:0] dim_lvl;
  } lmc_state_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_AUTO_OFF:   c = MODE_CODE_AUTO_OFF;
      MODE_AUTO_DIM:   c = MODE_CODE_AUTO_DIM;
      MODE_MOTION:     c = MODE_CODE_MOTION;
      MODE_MANUAL_ON:  c = MODE_CODE_MANUAL_ON;
      MODE_MANUAL_OFF: c = MODE_CODE_MANUAL_OFF;
      MODE_TEMP_DIM:   c = MODE_CODE_TEMP_DIM;
      MODE_FAULT:      c = MODE_CODE_FAULT;
      default:         c = MODE_CODE_AUTO_OFF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/lmc_trans.sv
// Mode transition logic: next mode, stored levels and changed flag for one event.
`default_nettype none
module lmc_trans
  import lmc_pkg::*;
(
  input  lmc_state_t         cur,
  input  logic [OP_W-1:0]    op,
  input  logic [7:0]         lvl,
  input  logic [LUX_W-1:0]   lux,
  input  logic [LUX_W-1:0]   thresh,
  output lmc_state_t         nxt,
  output logic               changed
);

  event_t             ev;
  mode_t              auto_m;
  logic [STORE_W-1:0] lvl_s;

  assign ev     = event_t'(op);
  assign auto_m = (lux <= thresh) ? MODE_AUTO_DIM : MODE_AUTO_OFF;
  assign lvl_s  = lvl[STORE_W-1:0];

  always_comb begin
    nxt     = cur;
    changed = 1'b0;
    if (ev == EV_FAULT && cur.mode != MODE_FAULT) begin
      nxt.mode = MODE_FAULT;
      changed  = 1'b1;
    end else if (ev == EV_OVR_ON && cur.mode != MODE_MANUAL_ON) begin
      nxt.man_lvl = lvl_s;
      nxt.mode    = MODE_MANUAL_ON;
      changed     = 1'b1;
    end else if (ev == EV_OVR_OFF && cur.mode != MODE_MANUAL_OFF &&
                 cur.mode != MODE_FAULT) begin
      nxt.mode = MODE_MANUAL_OFF;
      changed  = 1'b1;
    end else begin
      case (cur.mode)
        MODE_AUTO_OFF: begin
          if (ev == EV_DARK) begin
            nxt.mode = MODE_AUTO_DIM;
            changed  = 1'b1;
          end else if (ev == EV_TEMP_DIM) begin
            nxt.dim_lvl = lvl_s;
          end
        end
        MODE_AUTO_DIM: begin
          if (ev == EV_LIGHT) begin
            nxt.mode = MODE_AUTO_OFF;
            changed  = 1'b1;
          end else if (ev == EV_MOTION) begin
            nxt.mode = MODE_MOTION;
            changed  = 1'b1;
          end else if (ev == EV_TEMP_DIM) begin
            nxt.dim_lvl = lvl_s;
            nxt.mode    = MODE_TEMP_DIM;
            changed     = 1'b1;
          end
        end
        MODE_MOTION: begin
          if (ev == EV_MOTION_TO) begin
            nxt.mode = MODE_AUTO_DIM;
            changed  = 1'b1;
          end else if (ev == EV_LIGHT) begin
            nxt.mode = MODE_AUTO_OFF;
            changed  = 1'b1;
          end
        end
        MODE_MANUAL_ON, MODE_MANUAL_OFF: begin
          if (ev inside {EV_RESUME, EV_MAN_TO}) begin
            nxt.mode = auto_m;
            changed  = 1'b1;
          end
        end
        MODE_TEMP_DIM: begin
          if (ev == EV_MOTION) begin
            nxt.mode = MODE_MOTION;
            changed  = 1'b1;
          end else if (ev inside {EV_DIM_EXP, EV_RESUME}) begin
            nxt.mode = MODE_AUTO_DIM;
            changed  = 1'b1;
          end else if (ev == EV_LIGHT) begin
            nxt.mode = MODE_AUTO_OFF;
            changed  = 1'b1;
          end
        end
        MODE_FAULT: begin
          if (ev == EV_FAULT_CLR) begin
            nxt.mode = auto_m;
            changed  = 1'b1;
          end
        end
        default: begin
          nxt     = cur;
          changed = 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/light_mode_controller_unit.sv
// Top level of the lamp mode controller: input register, state, result register.
// Usage:
//   in_*  : one event request per handshake; in_tuser carries the event code,
//           in_tdata the override level and the ambient lux reading.
//   out_* : one result per event: mode, changed flag and both stored levels.
//   cfg_* : writes the lux threshold; cfg_ready is always high. Write only
//           while no event is in flight.
// An event passes through the input register, then the result register, before
//   its result shows on out_tvalid.
// Throughput: one event per cycle while out_tready is high; the limit is the mode
//   update that feeds the next event's transition lookup.
// Reset (rst_n low, synchronous): mode auto-off, both levels zero, threshold
//   1000, both pipeline registers empty.
// Stall: while out_tready is low the result holds; one more event waits in the
//   input register, and in_tready drops once both registers are full.
`default_nettype none
module light_mode_controller_unit
  import lmc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // [7:0] override_level, [23:8] ambient_lux
  input  wire logic [OP_W-1:0]        in_tuser,  // [3:0] operation
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata, // [2:0] mode, [3] changed,
                                                 // [11:4] manual_level,
                                                 // [19:12] temp_dim_level
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [LUX_W-1:0]       cfg_data
);

`include "light_mode_controller_unit_macros.svh"

  logic                   in_valid_r;
  logic [OP_W-1:0]        in_op_r;
  logic [7:0]             in_lvl_r;
  logic [LUX_W-1:0]       in_lux_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic [LUX_W-1:0]       thresh_r;
  lmc_state_t             state_r;
  lmc_state_t             state_nxt;
  logic                   chg;
  logic                   adv;
  logic                   in_acc;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  lmc_trans u_trans (
    .cur     (state_r),
    .op      (in_op_r),
    .lvl     (in_lvl_r),
    .lux     (in_lux_r),
    .thresh  (thresh_r),
    .nxt     (state_nxt),
    .changed (chg)
  );

  assign out_data_nxt = OUT_TDATA_W'({OUT_LVL_W'(state_nxt.dim_lvl),
                                      OUT_LVL_W'(state_nxt.man_lvl),
                                      chg,
                                      mode_code(state_nxt.mode)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      thresh_r      <= LUX_THRESH_RST;
      state_r.mode    <= MODE_AUTO_OFF;
      state_r.man_lvl <= '0;
      state_r.dim_lvl <= '0;
    end else begin
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r  <= in_tuser;
      in_lvl_r <= in_tdata[7:0];
      in_lux_r <= in_tdata[8 +: LUX_W];
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LMC_ASSERT(a_changed_iff_move,
    adv |-> (chg == (state_nxt.mode != state_r.mode)),
    "changed flag disagrees with mode move")
  `LMC_ASSERT(a_manual_latch,
    (adv && state_nxt.man_lvl != state_r.man_lvl) |-> (state_nxt.mode == MODE_MANUAL_ON),
    "manual level latched outside override on")
  `LMC_ASSERT(a_dim_latch,
    (adv && state_nxt.dim_lvl != state_r.dim_lvl) |->
      (state_r.mode == MODE_AUTO_OFF || state_r.mode == MODE_AUTO_DIM),
    "temp-dim level latched from wrong mode")
  `LMC_ASSERT(a_state_hold,
    (!$past(adv) && $past(rst_n)) |-> $stable(state_r),
    "state moved without an event")

endmodule
`default_nettype wire
